[src/pcm_pkg.sv]
package pcm_pkg;

  localparam int unsigned SIDE       = 512;
  localparam int unsigned SPIN_BITS  = 8;

  // lattice geometry, SIDE is a power of two
  localparam int unsigned HALF_ROWS  = SIDE / 2;
  localparam int unsigned ROW_BITS   = $clog2(HALF_ROWS);
  localparam int unsigned COL_BITS   = $clog2(SIDE);
  localparam int unsigned IDX_BITS   = ROW_BITS + COL_BITS;
  localparam int unsigned HALF_SITES = 1 << IDX_BITS;

  // q and spin-plus-offset need one bit more than a spin
  localparam int unsigned Q_W        = SPIN_BITS + 1;
  localparam int unsigned SUM_W      = SPIN_BITS + 1;

  localparam int unsigned HIST_DEPTH = 1 << SPIN_BITS;
  localparam int unsigned HIST_W     = 19;
  localparam int unsigned PAIR_W     = 20;
  localparam logic [HIST_W-1:0] HIST_MAX = {HIST_W{1'b1}};
  localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_UPDATE  = 2'd1,
    MODE_MEASURE = 2'd2,
    MODE_READ    = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPIN_STATES = 3'd0,
    CFG_THR_1       = 3'd1,
    CFG_THR_2       = 3'd2,
    CFG_THR_3       = 3'd3,
    CFG_THR_4       = 3'd4
  } cfg_idx_e;

endpackage

[src/pcm_ram.sv]
module pcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/pcm_mod.sv]
module pcm_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pcm_pkg::SUM_W-1:0] dividend_i,
  input  logic [pcm_pkg::Q_W-1:0]   divisor_i,
  output logic                      done_o,
  output logic [pcm_pkg::SUM_W-1:0] rem_o
);
  import pcm_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [SUM_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] dvd_q, dvd_d;
  logic [SUM_W:0]   trial;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    trial  = {rem_q, dvd_q[SUM_W-1]};
    if (start_i) begin
      cnt_d = CNT_W'(SUM_W);
      rem_d = '0;
      dvd_d = dividend_i;
    end else if (cnt_q != '0) begin
      if (trial >= (SUM_W+1)'(divisor_i)) begin
        rem_d = SUM_W'(trial - (SUM_W+1)'(divisor_i));
      end else begin
        rem_d = SUM_W'(trial);
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[src/potts_checkerboard_metropolis.sv]
// checkerboard metropolis engine for a periodic q-state potts lattice
//
// three channels, each valid/ready: a config write channel (register index,
// data, always ready), an input channel carrying one site command per
// transaction (load, update, measure, read) and a result channel giving one
// result transaction per command.
// after reset the block sweeps both lattice halves to zero, one site of each
// half per cycle for 131072 sites, with in_ready_o low; config writes are taken.
// a command then runs alone: four neighbour reads on the single read port of
// the other half, plus a registered read of the site itself. load and read
// pass through ST_READ, ST_WAIT and ST_FINISH, measure adds ST_HIST, and update
// adds ST_MOD for the serial remainder unit's (spin+offset) mod q and ST_EVAL.
// the result sits in an output register; a new command is accepted while it
// waits. when the receiver stalls with a result still held, the next command
// runs to completion and then waits for the output register to free up.
// measure totals are reported on the site that has last_site set, after
// which the histogram and pair total start again from zero.
module potts_checkerboard_metropolis (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pcm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic                          color_i,
  input  logic [7:0]                    row_i,
  input  logic [8:0]                    column_i,
  input  logic [7:0]                    spin_value_i,
  input  logic [31:0]                   proposal_random_i,
  input  logic [31:0]                   accept_random_i,
  input  logic                          last_site_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    spin_out_o,
  output logic                          flipped_o,
  output logic [19:0]                   equal_pair_count_o,
  output logic [18:0]                   max_state_count_o,
  output logic                          totals_valid_o
);
  import pcm_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_READ   = 8'b0000_0100,
    ST_WAIT   = 8'b0000_1000,
    ST_MOD    = 8'b0001_0000,
    ST_EVAL   = 8'b0010_0000,
    ST_HIST   = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_e;

  function automatic logic [2:0] count_eq(logic [SPIN_BITS-1:0] s,
                                          logic [SPIN_BITS-1:0] n0,
                                          logic [SPIN_BITS-1:0] n1,
                                          logic [SPIN_BITS-1:0] n2,
                                          logic [SPIN_BITS-1:0] n3);
    logic [2:0] n;
    n = 3'd0;
    n = n + 3'(n0 == s);
    n = n + 3'(n1 == s);
    n = n + 3'(n2 == s);
    n = n + 3'(n3 == s);
    return n;
  endfunction

  state_e state_q, state_d;

  // configuration
  logic [7:0]  spin_states_q, spin_states_d;
  logic [31:0] thr_q [4];
  logic [31:0] thr_d [4];

  // control
  logic [IDX_BITS-1:0]   clear_cnt_q, clear_cnt_d;
  logic [1:0]            rd_cnt_q, rd_cnt_d;
  logic                  cap_q, cap_d;
  logic [1:0]            cap_idx_q, cap_idx_d;
  logic [PAIR_W-1:0]     pair_q, pair_d;
  logic [HIST_W-1:0]     max_q, max_d;
  logic [HIST_DEPTH-1:0] hvalid_q, hvalid_d;
  logic                  out_valid_q, out_valid_d;

  // payload
  mode_e                 mode_q, mode_d;
  logic                  color_q, color_d;
  logic [ROW_BITS-1:0]   row_q, row_d;
  logic [COL_BITS-1:0]   col_q, col_d;
  logic [7:0]            val_q, val_d;
  logic [31:0]           prop_q, prop_d;
  logic [31:0]           acc_q, acc_d;
  logic                  last_q, last_d;
  logic [SPIN_BITS-1:0]  old_q, old_d;
  logic [SPIN_BITS-1:0]  nb_q [4];
  logic [SPIN_BITS-1:0]  nb_d [4];
  logic [Q_W-1:0]        offset_q, offset_d;
  logic [SPIN_BITS-1:0]  res_spin_q, res_spin_d;
  logic                  res_flip_q, res_flip_d;
  logic [PAIR_W-1:0]     res_pairs_q, res_pairs_d;
  logic [HIST_W-1:0]     res_max_q, res_max_d;
  logic                  res_tot_q, res_tot_d;
  logic [7:0]            out_spin_q, out_spin_d;
  logic                  out_flip_q, out_flip_d;
  logic [PAIR_W-1:0]     out_pairs_q, out_pairs_d;
  logic [HIST_W-1:0]     out_max_q, out_max_d;
  logic                  out_tot_q, out_tot_d;

  // memories
  logic                 w_we, b_we, h_we;
  logic [IDX_BITS-1:0]  w_waddr, b_waddr, w_raddr, b_raddr;
  logic [SPIN_BITS-1:0] w_wdata, b_wdata, w_rdata, b_rdata;
  logic [HIST_W-1:0]    h_wdata, h_rdata;
  logic                 self_we;
  logic [SPIN_BITS-1:0] self_wdata, self_rdata, other_rdata;
  logic [IDX_BITS-1:0]  site_idx, nb_addr;
  logic [ROW_BITS-1:0]  south_row;

  // arithmetic
  logic [8:0]           q9;
  logic [Q_W-1:0]       q_eff;
  logic [8:0]           qm1_9;
  logic [SPIN_BITS-1:0] load_spin;
  logic [32+Q_W-1:0]    prop_prod;
  logic                 mod_start, mod_done;
  logic [SUM_W-1:0]     mod_rem;
  logic [SPIN_BITS-1:0] new_spin;
  logic [2:0]           e_old, e_new, e_diff;
  logic                 accept;
  logic [HIST_W-1:0]    bin_old, bin_new;
  logic [PAIR_W:0]      pair_sum;
  logic [PAIR_W-1:0]    pair_new;
  logic [HIST_W-1:0]    max_new;

  assign q9 = (spin_states_q < 8'd2) ? 9'd2 :
              ((9'(spin_states_q) > 9'(HIST_DEPTH)) ? 9'(HIST_DEPTH) : 9'(spin_states_q));
  assign q_eff = Q_W'(q9);
  assign qm1_9 = q9 - 9'd1;
  assign load_spin = (9'(val_q) > qm1_9) ? SPIN_BITS'(qm1_9) : SPIN_BITS'(val_q);
  assign prop_prod = (32+Q_W)'(prop_q) * (32+Q_W)'(q_eff - Q_W'(1));

  assign site_idx  = {row_q, col_q};
  assign south_row = (color_q ^ col_q[0]) ? row_q + ROW_BITS'(1) : row_q - ROW_BITS'(1);

  always_comb begin
    unique case (rd_cnt_q)
      2'd0:    nb_addr = {row_q, col_q};
      2'd1:    nb_addr = {row_q, col_q + COL_BITS'(1)};
      2'd2:    nb_addr = {row_q, col_q - COL_BITS'(1)};
      default: nb_addr = {south_row, col_q};
    endcase
  end

  assign self_rdata  = color_q ? b_rdata : w_rdata;
  assign other_rdata = color_q ? w_rdata : b_rdata;
  assign w_raddr     = color_q ? nb_addr : site_idx;
  assign b_raddr     = color_q ? site_idx : nb_addr;

  always_comb begin
    if (state_q == ST_CLEAR) begin
      w_we = 1'b1;
      b_we = 1'b1;
      w_waddr = clear_cnt_q;
      b_waddr = clear_cnt_q;
      w_wdata = '0;
      b_wdata = '0;
    end else begin
      w_we = self_we && !color_q;
      b_we = self_we && color_q;
      w_waddr = site_idx;
      b_waddr = site_idx;
      w_wdata = self_wdata;
      b_wdata = self_wdata;
    end
  end

  pcm_ram #(.WIDTH(SPIN_BITS), .DEPTH(HALF_SITES)) u_white (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  pcm_ram #(.WIDTH(SPIN_BITS), .DEPTH(HALF_SITES)) u_black (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  pcm_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (old_q),
    .wdata_i (h_wdata),
    .raddr_i (old_q),
    .rdata_o (h_rdata)
  );

  assign mod_start = (state_q == ST_WAIT) && (mode_q == MODE_UPDATE);

  pcm_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (SUM_W'(old_q) + SUM_W'(offset_q)),
    .divisor_i  (q_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign new_spin = SPIN_BITS'(mod_rem);
  assign e_old    = count_eq(old_q, nb_q[0], nb_q[1], nb_q[2], nb_q[3]);
  assign e_new    = count_eq(new_spin, nb_q[0], nb_q[1], nb_q[2], nb_q[3]);
  assign e_diff   = e_old - e_new;
  assign accept   = (e_old <= e_new) || (acc_q <= thr_q[2'(e_diff - 3'd1)]);

  // unwritten bins read as zero
  assign bin_old  = hvalid_q[old_q] ? h_rdata : '0;
  assign bin_new  = (bin_old < HIST_MAX) ? bin_old + HIST_W'(1) : bin_old;
  assign pair_sum = (PAIR_W+1)'(pair_q) + (color_q ? (PAIR_W+1)'(0) : (PAIR_W+1)'(e_old));
  assign pair_new = (pair_sum > (PAIR_W+1)'(PAIR_MAX)) ? PAIR_MAX : PAIR_W'(pair_sum);
  assign max_new  = (bin_new > max_q) ? bin_new : max_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    spin_states_d = spin_states_q;
    thr_d         = thr_q;
    clear_cnt_d   = clear_cnt_q;
    rd_cnt_d      = rd_cnt_q;
    cap_d         = 1'b0;
    cap_idx_d     = rd_cnt_q;
    pair_d        = pair_q;
    max_d         = max_q;
    hvalid_d      = hvalid_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    mode_d        = mode_q;
    color_d       = color_q;
    row_d         = row_q;
    col_d         = col_q;
    val_d         = val_q;
    prop_d        = prop_q;
    acc_d         = acc_q;
    last_d        = last_q;
    old_d         = old_q;
    nb_d          = nb_q;
    offset_d      = offset_q;
    res_spin_d    = res_spin_q;
    res_flip_d    = res_flip_q;
    res_pairs_d   = res_pairs_q;
    res_max_d     = res_max_q;
    res_tot_d     = res_tot_q;
    out_spin_d    = out_spin_q;
    out_flip_d    = out_flip_q;
    out_pairs_d   = out_pairs_q;
    out_max_d     = out_max_q;
    out_tot_d     = out_tot_q;
    self_we       = 1'b0;
    self_wdata    = load_spin;
    h_we          = 1'b0;
    h_wdata       = bin_new;

    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SPIN_STATES: spin_states_d = cfg_data_i[7:0];
        CFG_THR_1:       thr_d[0] = cfg_data_i;
        CFG_THR_2:       thr_d[1] = cfg_data_i;
        CFG_THR_3:       thr_d[2] = cfg_data_i;
        CFG_THR_4:       thr_d[3] = cfg_data_i;
        default:         ;
      endcase
    end

    // read data lands in the cycle after its address
    if (cap_q) begin
      nb_d[cap_idx_q] = other_rdata;
      if (cap_idx_q == 2'd0) begin
        old_d = self_rdata;
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        clear_cnt_d = clear_cnt_q + IDX_BITS'(1);
        if (clear_cnt_q == IDX_BITS'(HALF_SITES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_e'(mode_i);
          color_d  = color_i;
          row_d    = ROW_BITS'(row_i);
          col_d    = COL_BITS'(column_i);
          val_d    = spin_value_i;
          prop_d   = proposal_random_i;
          acc_d    = accept_random_i;
          last_d   = last_site_i;
          rd_cnt_d = 2'd0;
          state_d  = ST_READ;
        end
      end
      ST_READ: begin
        cap_d    = 1'b1;
        rd_cnt_d = rd_cnt_q + 2'd1;
        if (rd_cnt_q == 2'd0) begin
          offset_d = prop_prod[32+Q_W-1:32] + Q_W'(1);
        end
        if (rd_cnt_q == 2'd3) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        res_flip_d  = 1'b0;
        res_pairs_d = '0;
        res_max_d   = '0;
        res_tot_d   = 1'b0;
        unique case (mode_q)
          MODE_LOAD: begin
            self_we    = 1'b1;
            res_spin_d = load_spin;
            state_d    = ST_FINISH;
          end
          MODE_READ: begin
            res_spin_d = old_q;
            state_d    = ST_FINISH;
          end
          MODE_UPDATE: state_d = ST_MOD;
          default:     state_d = ST_HIST;
        endcase
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        self_wdata = new_spin;
        self_we    = accept;
        res_flip_d = accept;
        res_spin_d = accept ? new_spin : old_q;
        state_d    = ST_FINISH;
      end
      ST_HIST: begin
        h_we       = 1'b1;
        res_spin_d = old_q;
        hvalid_d[old_q] = 1'b1;
        if (last_q) begin
          res_pairs_d = pair_new;
          res_max_d   = max_new;
          res_tot_d   = 1'b1;
          hvalid_d    = '0;
          pair_d      = '0;
          max_d       = '0;
        end else begin
          pair_d = pair_new;
          max_d  = max_new;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_spin_d  = 8'(res_spin_q);
          out_flip_d  = res_flip_q;
          out_pairs_d = res_pairs_q;
          out_max_d   = res_max_q;
          out_tot_d   = res_tot_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      spin_states_q <= 8'd9;
      thr_q[0]      <= 32'd1029293208;
      thr_q[1]      <= 32'd246672857;
      thr_q[2]      <= 32'd59115928;
      thr_q[3]      <= 32'd14164802;
      clear_cnt_q   <= '0;
      rd_cnt_q      <= '0;
      cap_q         <= 1'b0;
      cap_idx_q     <= '0;
      pair_q        <= '0;
      max_q         <= '0;
      hvalid_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      spin_states_q <= spin_states_d;
      thr_q         <= thr_d;
      clear_cnt_q   <= clear_cnt_d;
      rd_cnt_q      <= rd_cnt_d;
      cap_q         <= cap_d;
      cap_idx_q     <= cap_idx_d;
      pair_q        <= pair_d;
      max_q         <= max_d;
      hvalid_q      <= hvalid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    color_q     <= color_d;
    row_q       <= row_d;
    col_q       <= col_d;
    val_q       <= val_d;
    prop_q      <= prop_d;
    acc_q       <= acc_d;
    last_q      <= last_d;
    old_q       <= old_d;
    nb_q        <= nb_d;
    offset_q    <= offset_d;
    res_spin_q  <= res_spin_d;
    res_flip_q  <= res_flip_d;
    res_pairs_q <= res_pairs_d;
    res_max_q   <= res_max_d;
    res_tot_q   <= res_tot_d;
    out_spin_q  <= out_spin_d;
    out_flip_q  <= out_flip_d;
    out_pairs_q <= out_pairs_d;
    out_max_q   <= out_max_d;
    out_tot_q   <= out_tot_d;
  end

  assign out_valid_o        = out_valid_q;
  assign spin_out_o         = out_spin_q;
  assign flipped_o          = out_flip_q;
  assign equal_pair_count_o = out_pairs_q;
  assign max_state_count_o  = out_max_q;
  assign totals_valid_o     = out_tot_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == ST_MOD)
    else $error("remainder unit finished outside its wait state");

  a_update_below_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> Q_W'(new_spin) < q_eff)
    else $error("updated spin not below q");

  a_totals_no_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && totals_valid_o |-> !flipped_o)
    else $error("totals reported with a flip");

  a_no_accept_when_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("command taken during clearing pass");

endmodule
